@@ rtl/core/tsa_pkg.sv @@
//------------------------------------------------------------------------------
// tsa_pkg
// Shared widths, constants and codes of the timestamp arithmetic unit.
//------------------------------------------------------------------------------
package tsa_pkg;

	localparam int OP_W     = 3;
	localparam int MICROS_W = 20;
	localparam int OFFSET_W = 17;
	localparam int ORDER_W  = 2;
	localparam int WIDE_W   = 22;

	localparam logic [WIDE_W-1:0] USEC_PER_SEC  = 22'd1000000;
	localparam logic [WIDE_W-1:0] USEC_TWO_SEC  = 22'd2000000;

	localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'b11;
	localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'b00;
	localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'b01;

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_CMP  = 3'd2,
		OP_RDN  = 3'd3,
		OP_RUP  = 3'd4
	} tsa_op_t;

	// What the back end still has to do with an item.
	typedef enum logic [1:0] {
		KIND_DONE = 2'd0,
		KIND_RMIC = 2'd1,
		KIND_RSEC = 2'd2
	} tsa_kind_t;

endpackage

@@ rtl/core/tsa_if.sv @@
//------------------------------------------------------------------------------
// tsa_if
// Channel interfaces of the timestamp arithmetic unit.
//------------------------------------------------------------------------------
interface tsa_req_if #(parameter int SW = 48);
	logic                          valid;
	logic                          ready;
	logic [tsa_pkg::OP_W-1:0]      operation;
	logic signed [SW-1:0]          a_seconds;
	logic [tsa_pkg::MICROS_W-1:0]  a_micros;
	logic signed [SW-1:0]          b_seconds;
	logic [tsa_pkg::MICROS_W-1:0]  b_micros;

	modport source (output valid, operation, a_seconds, a_micros, b_seconds, b_micros,
		input ready);
	modport sink (input valid, operation, a_seconds, a_micros, b_seconds, b_micros,
		output ready);
endinterface

interface tsa_rsp_if #(parameter int SW = 48);
	logic                                valid;
	logic                                ready;
	logic signed [SW-1:0]                res_seconds;
	logic [tsa_pkg::MICROS_W-1:0]        res_micros;
	logic signed [tsa_pkg::ORDER_W-1:0]  order;
	logic                                bad_interval;

	modport source (output valid, res_seconds, res_micros, order, bad_interval,
		input ready);
	modport sink (input valid, res_seconds, res_micros, order, bad_interval,
		output ready);
endinterface

interface tsa_cfg_if;
	logic                                valid;
	logic                                ready;
	logic signed [tsa_pkg::OFFSET_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/tsa_div.sv @@
//------------------------------------------------------------------------------
// tsa_div
// Pipelined unsigned remainder, one quotient bit per stage, with side data.
//------------------------------------------------------------------------------
module tsa_div #(
	parameter int W     = 48,
	parameter int CTX_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [W-1:0]     dividend,
	input  logic [W-1:0]     divisor,
	input  logic [CTX_W-1:0] ctx_in,
	output logic             out_valid,
	output logic [W-1:0]     rem,
	output logic [CTX_W-1:0] ctx_out
);

	logic             vld_s [W+1];
	logic [W-1:0]     rem_s [W+1];
	logic [W-1:0]     num_s [W+1];
	logic [W-1:0]     den_s [W+1];
	logic [CTX_W-1:0] ctx_s [W+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign num_s[0] = dividend;
	assign den_s[0] = divisor;
	assign ctx_s[0] = ctx_in;

	for (genvar g = 0; g < W; g++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		logic       fits;

		always_comb begin
			trial = {rem_s[g], num_s[g][W-1]};
			diff  = trial - {1'b0, den_s[g]};
			fits  = trial >= {1'b0, den_s[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= fits ? diff[W-1:0] : trial[W-1:0];
				num_s[g+1] <= {num_s[g][W-2:0], 1'b0};
				den_s[g+1] <= den_s[g];
				ctx_s[g+1] <= ctx_s[g];
			end
		end
	end

	assign out_valid = vld_s[W];
	assign rem       = rem_s[W];
	assign ctx_out   = ctx_s[W];

endmodule

@@ rtl/core/timestamp_sec_usec_alu_top.sv @@
//------------------------------------------------------------------------------
// timestamp_sec_usec_alu_top
// Add, subtract, compare and local-time rounding of seconds/microseconds pairs.
//------------------------------------------------------------------------------
// Data path: front-end register, remainder pipeline, back-end register, output register.
// Throughput: one transaction per cycle when not stalled, set by the remainder pipeline.
// The whole pipeline stalls together while a result waits on the output.
// Reset clears all valid bits and sets the UTC offset to zero.
module timestamp_sec_usec_alu_top #(
	parameter int SECONDS_WIDTH = 48
) (
	input logic    clk,
	input logic    arst_n,
	tsa_req_if.sink   req,
	tsa_rsp_if.source rsp,
	tsa_cfg_if.sink   cfg
);
	import tsa_pkg::*;

	localparam int W = SECONDS_WIDTH;

	typedef struct packed {
		tsa_kind_t             kind;
		logic                  up;
		logic                  sx;
		logic [ORDER_W-1:0]    ord;
		logic                  bad;
		logic [OFFSET_W-1:0]   off;
		logic [W-1:0]          rs;
		logic [MICROS_W-1:0]   ru;
		logic [W-1:0]          aux;
	} ctx_t;

	typedef struct packed {
		tsa_kind_t             kind;
		logic [ORDER_W-1:0]    ord;
		logic                  bad;
		logic [OFFSET_W-1:0]   off;
		logic [W-1:0]          rs;
		logic [MICROS_W-1:0]   ru;
		logic [WIDE_W-1:0]     m;
		logic [W-1:0]          adj;
	} back_t;

	logic [OFFSET_W-1:0] offset_q;
	logic                en;

	logic                valid_s1;
	ctx_t                ctx_s1;
	logic [W-1:0]        num_s1;
	logic [W-1:0]        den_s1;
	ctx_t                fctx;
	logic [W-1:0]        fnum;
	logic [W-1:0]        fden;

	logic                div_valid;
	logic [W-1:0]        div_rem;
	logic [$bits(ctx_t)-1:0] div_ctx_raw;
	ctx_t                div_ctx;

	logic                valid_s2;
	back_t               back_s2;
	back_t               bnext;

	logic                out_valid_q;
	logic [W-1:0]        out_rs_q;
	logic [MICROS_W-1:0] out_ru_q;
	logic [ORDER_W-1:0]  out_ord_q;
	logic                out_bad_q;
	logic [W-1:0]        fin_rs;
	logic [MICROS_W-1:0] fin_ru;

	// Front end signals.
	logic [W-1:0]        as;
	logic [W-1:0]        bs;
	logic [W-1:0]        off_w;
	logic [W-1:0]        local_s;
	logic [WIDE_W-1:0]   au_w;
	logic [WIDE_W-1:0]   bu_w;
	logic [WIDE_W-1:0]   sum_u;
	logic [WIDE_W-1:0]   dif0;
	logic [WIDE_W-1:0]   dif1;
	logic [WIDE_W-1:0]   dif2;
	logic                brw1;
	logic                brw2;
	logic                cry;

	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg.valid) begin
			offset_q <= cfg.data;
		end
	end

	always_comb begin
		as      = req.a_seconds;
		bs      = req.b_seconds;
		off_w   = {{(W-OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};
		local_s = as + off_w;
		au_w    = {2'b00, req.a_micros};
		bu_w    = {2'b00, req.b_micros};
		sum_u   = au_w + bu_w;
		dif0    = au_w - bu_w;
		brw1    = dif0[WIDE_W-1];
		dif1    = brw1 ? dif0 + USEC_PER_SEC : dif0;
		brw2    = dif1[WIDE_W-1];
		dif2    = brw2 ? dif1 + USEC_PER_SEC : dif1;
		cry     = !dif2[WIDE_W-1] && (dif2 >= USEC_PER_SEC);

		fctx      = '0;
		fctx.kind = KIND_DONE;
		fctx.off  = offset_q;
		fnum      = '0;
		fden      = '0;

		unique case (req.operation)
			OP_ADD: begin
				if (sum_u >= USEC_TWO_SEC) begin
					fctx.rs = as + bs + W'(2);
					fctx.ru = MICROS_W'(sum_u - USEC_TWO_SEC);
				end else if (sum_u >= USEC_PER_SEC) begin
					fctx.rs = as + bs + W'(1);
					fctx.ru = MICROS_W'(sum_u - USEC_PER_SEC);
				end else begin
					fctx.rs = as + bs;
					fctx.ru = MICROS_W'(sum_u);
				end
			end
			OP_SUB: begin
				fctx.rs = as - bs - W'(brw1) - W'(brw2) + W'(cry);
				fctx.ru = cry ? MICROS_W'(dif2 - USEC_PER_SEC) : MICROS_W'(dif2);
			end
			OP_CMP: begin
				if ($signed(as) > $signed(bs)) begin
					fctx.ord = ORDER_GREATER;
				end else if ($signed(as) < $signed(bs)) begin
					fctx.ord = ORDER_LESS;
				end else if (req.a_micros > req.b_micros) begin
					fctx.ord = ORDER_GREATER;
				end else if (req.a_micros < req.b_micros) begin
					fctx.ord = ORDER_LESS;
				end else begin
					fctx.ord = ORDER_EQUAL;
				end
			end
			OP_RDN, OP_RUP: begin
				fctx.up = (req.operation == OP_RUP);
				if (bs == '0 && req.b_micros == '0) begin
					fctx.bad = 1'b1;
					if (au_w >= USEC_PER_SEC) begin
						fctx.rs = as + W'(1);
						fctx.ru = MICROS_W'(au_w - USEC_PER_SEC);
					end else begin
						fctx.rs = as;
						fctx.ru = req.a_micros;
					end
				end else if (bs == '0) begin
					fctx.kind = KIND_RMIC;
					fctx.rs   = as;
					fctx.ru   = req.a_micros;
					fctx.aux  = W'(req.b_micros);
					fnum      = W'(req.a_micros);
					fden      = W'(req.b_micros);
				end else begin
					fctx.kind = KIND_RSEC;
					fctx.sx   = local_s[W-1];
					fctx.rs   = local_s;
					fctx.aux  = bs;
					fnum      = local_s[W-1] ? -local_s : local_s;
					fden      = bs[W-1] ? -bs : bs;
				end
			end
			default: begin
				fctx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= fctx;
			num_s1 <= fnum;
			den_s1 <= fden;
		end
	end

	tsa_div #(
		.W     (W),
		.CTX_W ($bits(ctx_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.dividend  (num_s1),
		.divisor   (den_s1),
		.ctx_in    (ctx_s1),
		.out_valid (div_valid),
		.rem       (div_rem),
		.ctx_out   (div_ctx_raw)
	);

	assign div_ctx = ctx_t'(div_ctx_raw);

	always_comb begin
		logic [W-1:0]        srem;
		logic [MICROS_W-1:0] urem;
		srem = div_ctx.sx ? -div_rem : div_rem;
		urem = div_rem[MICROS_W-1:0];

		bnext      = '0;
		bnext.kind = div_ctx.kind;
		bnext.ord  = div_ctx.ord;
		bnext.bad  = div_ctx.bad;
		bnext.off  = div_ctx.off;
		bnext.rs   = div_ctx.rs;
		bnext.ru   = div_ctx.ru;

		if (!div_ctx.up) begin
			bnext.m   = {2'b00, div_ctx.ru} - {2'b00, urem};
			bnext.adj = -srem;
		end else if (div_rem == '0) begin
			bnext.m   = {2'b00, div_ctx.ru};
			bnext.adj = '0;
		end else begin
			bnext.m   = {2'b00, div_ctx.ru} + {2'b00, div_ctx.aux[MICROS_W-1:0]}
				- {2'b00, urem};
			bnext.adj = div_ctx.aux - srem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			back_s2 <= bnext;
		end
	end

	always_comb begin
		fin_rs = back_s2.rs;
		fin_ru = back_s2.ru;
		unique case (back_s2.kind)
			KIND_RMIC: begin
				if (back_s2.m >= USEC_TWO_SEC) begin
					fin_rs = back_s2.rs + W'(2);
					fin_ru = MICROS_W'(back_s2.m - USEC_TWO_SEC);
				end else if (back_s2.m >= USEC_PER_SEC) begin
					fin_rs = back_s2.rs + W'(1);
					fin_ru = MICROS_W'(back_s2.m - USEC_PER_SEC);
				end else begin
					fin_ru = MICROS_W'(back_s2.m);
				end
			end
			KIND_RSEC: begin
				fin_rs = back_s2.rs + back_s2.adj
					- {{(W-OFFSET_W){back_s2.off[OFFSET_W-1]}}, back_s2.off};
				fin_ru = '0;
			end
			default: begin
				fin_rs = back_s2.rs;
				fin_ru = back_s2.ru;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rs_q  <= fin_rs;
			out_ru_q  <= fin_ru;
			out_ord_q <= back_s2.ord;
			out_bad_q <= back_s2.bad;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.res_seconds  = out_rs_q;
	assign rsp.res_micros   = out_ru_q;
	assign rsp.order        = out_ord_q;
	assign rsp.bad_interval = out_bad_q;

endmodule

@@ sim/tsa_checker.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tsa_checker
// Watches the request, response and offset channels of the timestamp unit,
// predicts every result from the accepted request and the current UTC offset,
// and compares the results in order, field by field.
//------------------------------------------------------------------------------
module tsa_checker #(
	parameter int SW = 48
) (
	input  logic  clk,
	input  logic  arst_n,
	tsa_req_if    req,
	tsa_rsp_if    rsp,
	tsa_cfg_if    cfg,
	output int    fail_count,
	output int    pending
);
	import tsa_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic signed [SW-1:0] a_seconds;
		logic [MICROS_W-1:0] a_micros;
		logic signed [SW-1:0] b_seconds;
		logic [MICROS_W-1:0] b_micros;
	} stamp_req_t;

	typedef struct packed {
		logic [SW-1:0]       res_seconds;
		logic [MICROS_W-1:0] res_micros;
		logic [ORDER_W-1:0]  order;
		logic                bad_interval;
	} stamp_res_t;

	localparam longint MEGA = 1000000;

	logic signed [OFFSET_W-1:0] utc_offset;
	stamp_res_t                 stamps_due[$];

	function automatic stamp_res_t predict_stamp(stamp_req_t it, logic signed [OFFSET_W-1:0] ofs);
		stamp_res_t r;
		longint a_s, b_s, au, bu, off, t, d, x, rem, m, q;
		logic [SW-1:0] local_s;
		begin
			r = '0;
			a_s = it.a_seconds;
			b_s = it.b_seconds;
			au = it.a_micros;
			bu = it.b_micros;
			off = ofs;
			case (it.operation)
				OP_ADD: begin
					t = au + bu;
					r.res_seconds = a_s + b_s + t / MEGA;
					r.res_micros = t % MEGA;
				end
				OP_SUB: begin
					d = au - bu;
					t = 0;
					while (d < 0) begin
						d += MEGA;
						t++;
					end
					r.res_seconds = a_s - b_s - t + d / MEGA;
					r.res_micros = d % MEGA;
				end
				OP_CMP: begin
					if (a_s > b_s) r.order = ORDER_GREATER;
					else if (a_s < b_s) r.order = ORDER_LESS;
					else if (au > bu) r.order = ORDER_GREATER;
					else if (au < bu) r.order = ORDER_LESS;
					else r.order = ORDER_EQUAL;
				end
				OP_RDN, OP_RUP: begin
					local_s = a_s + off;
					x = {{(64-SW){local_s[SW-1]}}, local_s};
					if (b_s == 0 && bu == 0) begin
						r.bad_interval = 1'b1;
						r.res_seconds = a_s + au / MEGA;
						r.res_micros = au % MEGA;
					end else if (b_s == 0) begin
						rem = au % bu;
						if (it.operation == OP_RDN) m = au - rem;
						else if (rem == 0) m = au;
						else m = au + (bu - rem);
						r.res_seconds = x + m / MEGA - off;
						r.res_micros = m % MEGA;
					end else begin
						rem = (b_s == -1) ? 0 : x % b_s;
						if (it.operation == OP_RDN) q = x - rem;
						else if (rem == 0) q = x;
						else q = x + (b_s - rem);
						r.res_seconds = q - off;
					end
				end
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stamp_req_t it;
		stamp_res_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			utc_offset <= '0;
			fail_count <= 0;
			pending <= 0;
			stamps_due.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				utc_offset <= cfg.data;
			if (req.valid && req.ready) begin
				it.operation = req.operation;
				it.a_seconds = req.a_seconds;
				it.a_micros = req.a_micros;
				it.b_seconds = req.b_seconds;
				it.b_micros = req.b_micros;
				stamps_due.push_back(predict_stamp(it, utc_offset));
			end
			if (rsp.valid && rsp.ready) begin
				if (stamps_due.size() == 0) begin
					$error("result transaction with no request outstanding");
					errs++;
				end else begin
					want = stamps_due.pop_front();
					if (rsp.res_seconds !== want.res_seconds) begin
						$error("res_seconds expected %0h actual %0h", want.res_seconds,
							rsp.res_seconds);
						errs++;
					end
					if (rsp.res_micros !== want.res_micros) begin
						$error("res_micros expected %0d actual %0d", want.res_micros,
							rsp.res_micros);
						errs++;
					end
					if (rsp.order !== want.order) begin
						$error("order expected %0b actual %0b", want.order, rsp.order);
						errs++;
					end
					if (rsp.bad_interval !== want.bad_interval) begin
						$error("bad_interval expected %0b actual %0b", want.bad_interval,
							rsp.bad_interval);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= stamps_due.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top
// Drives the timestamp unit with directed and random operations under several
// UTC offsets, with random idle cycles on both sides, a long output stall and
// a full drain, and reports the checker's verdict.
//------------------------------------------------------------------------------
module tb_top;
	import tsa_pkg::*;

	localparam int SW = 48;
	localparam int LATENCY = SW + 3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   hold_asks = 0;

	tsa_req_if #(.SW(SW)) req_ch();
	tsa_rsp_if #(.SW(SW)) rsp_ch();
	tsa_cfg_if            cfg_ch();

	timestamp_sec_usec_alu_top #(.SECONDS_WIDTH(SW)) dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	tsa_checker #(.SW(SW)) checker_i (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
		.fail_count(fail_count), .pending(pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.a_seconds = '0;
		req_ch.a_micros = '0;
		req_ch.b_seconds = '0;
		req_ch.b_micros = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
	end

	// Result side: random stalls per transaction, plus a single long hold-off.
	initial begin
		int stall;
		int holds_done;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			if (holds_done != hold_asks) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				holds_done++;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	int burst_left = 0;

	task automatic send_stamp(logic [OP_W-1:0] op, logic [SW-1:0] as, logic [MICROS_W-1:0] au,
		logic [SW-1:0] bs, logic [MICROS_W-1:0] bu);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 17);
			if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 40);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.a_seconds <= as;
		req_ch.a_micros <= au;
		req_ch.b_seconds <= bs;
		req_ch.b_micros <= bu;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_stamps();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_offset(logic signed [OFFSET_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [SW-1:0] rand_seconds();
		case ($urandom_range(0, 5))
			0: return {1'b0, {(SW-1){1'b1}}} - $urandom_range(0, 3);
			1: return {1'b1, {(SW-1){1'b0}}} + $urandom_range(0, 3);
			2: return SW'(longint'($urandom_range(0, 200000)) - 64'sd100000);
			3: return {$urandom, $urandom};
			default: return 48'd1700000000 + $urandom_range(0, 1 << 24);
		endcase
	endfunction

	function automatic logic [MICROS_W-1:0] rand_micros();
		case ($urandom_range(0, 7))
			0: return 20'd999999 - $urandom_range(0, 2);
			1: return $urandom_range(1000000, 1048575);
			2: return $urandom_range(0, 2);
			default: return $urandom_range(0, 999999);
		endcase
	endfunction

	task automatic send_random();
		logic [OP_W-1:0] op;
		logic [SW-1:0] as, bs;
		logic [MICROS_W-1:0] au, bu;
		op = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
		as = rand_seconds();
		au = rand_micros();
		bs = rand_seconds();
		bu = rand_micros();
		if (op == OP_CMP && $urandom_range(0, 2) == 0) bs = as;
		if (op == OP_RDN || op == OP_RUP) begin
			case ($urandom_range(0, 9))
				0: begin bs = '0; bu = '0; end
				1, 2, 3: begin bs = '0; bu = $urandom_range(1, 999999); end
				4: begin bs = '0; bu = $urandom_range(1, 1048575); end
				5: bs = -SW'($urandom_range(1, 86400));
				6: bs = {$urandom, $urandom};
				default: bs = $urandom_range(1, 86400);
			endcase
		end
		send_stamp(op, as, au, bs, bu);
	endtask

	initial begin
		logic [SW-1:0] smax, smin;
		logic signed [OFFSET_W-1:0] offsets[4];
		smax = {1'b0, {(SW-1){1'b1}}};
		smin = {1'b1, {(SW-1){1'b0}}};
		offsets[0] = -17'sd50400;
		offsets[1] = 17'sd50400;
		offsets[2] = 17'sd0;
		offsets[3] = $urandom_range(0, 100800) - 50400;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_offset(17'sd3600);
		send_stamp(OP_ADD, smax, 20'd999999, 48'd0, 20'd1);
		send_stamp(OP_ADD, smin, 20'd1048575, smin, 20'd1048575);
		send_stamp(OP_SUB, 48'd5, 20'd0, 48'd3, 20'd999999);
		send_stamp(OP_SUB, smin, 20'd0, 48'd1, 20'd1048575);
		send_stamp(OP_SUB, 48'd0, 20'd1048575, 48'd0, 20'd0);
		send_stamp(OP_CMP, -48'sd1, 20'd5, 48'd1, 20'd5);
		send_stamp(OP_CMP, 48'd7, 20'd9, 48'd7, 20'd3);
		send_stamp(OP_CMP, 48'd7, 20'd3, 48'd7, 20'd9);
		send_stamp(OP_CMP, smin, 20'd0, smin, 20'd0);
		send_stamp(OP_CMP, smax, 20'd0, smin, 20'd0);
		send_stamp(OP_RDN, 48'd1000, 20'd999999, 48'd0, 20'd300000);
		send_stamp(OP_RUP, 48'd1000, 20'd999999, 48'd0, 20'd300000);
		send_stamp(OP_RUP, 48'd1000, 20'd600000, 48'd0, 20'd300000);
		send_stamp(OP_RDN, -48'sd100000, 20'd123, 48'd3600, 20'd0);
		send_stamp(OP_RUP, -48'sd100000, 20'd123, 48'd3600, 20'd0);
		send_stamp(OP_RDN, 48'd12345, 20'd5, -48'sd1, 20'd0);
		send_stamp(OP_RUP, 48'd12345, 20'd5, -48'sd7, 20'd0);
		send_stamp(OP_RDN, 48'd9, 20'd1048575, 48'd0, 20'd0);
		send_stamp(OP_RUP, 48'd9, 20'd1048575, 48'd0, 20'd1048575);
		send_stamp(OP_RDN, smax, 20'd0, 48'd86400, 20'd0);
		send_stamp(3'd5, smax, 20'd1, smin, 20'd2);
		send_stamp(3'd6, 48'd1, 20'd1, 48'd1, 20'd1);
		send_stamp(3'd7, smin, 20'd1048575, smax, 20'd1048575);
		drain_stamps();

		for (int ph = 0; ph < 4; ph++) begin
			write_offset(offsets[ph]);
			if (ph == 1) hold_asks++;
			for (int i = 0; i < 120; i++) begin
				send_random();
				if (ph == 2 && i == 60) begin
					req_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
			drain_stamps();
		end

		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
